// ----- rtl/core/fat_pkg.sv -----
// fat_pkg: widths, codes and constants shared by the chain allocator files.
// No dependencies.
package fat_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int BLK_W       = 12;
	localparam int CNT_W       = 13;
	localparam int ENTRY_W     = 32;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	// usable blocks never exceed the table nor the 12-bit block space
	localparam int USABLE_MAX_I = (TABLE_DEPTH < (1 << BLK_W)) ? TABLE_DEPTH : (1 << BLK_W);
	localparam logic [CNT_W-1:0] USABLE_MAX = CNT_W'(USABLE_MAX_I);
	localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(TABLE_DEPTH - 1);

	localparam logic [ENTRY_W-1:0] END_MARK = '1;
	localparam logic [CNT_W-1:0]   TOTAL_RESET    = 13'd4096;
	localparam logic [BLK_W-1:0]   RESERVED_RESET = 12'd4;

	typedef enum logic [2:0] {
		CMD_FORMAT = 3'd0,
		CMD_ALLOC  = 3'd1,
		CMD_FREE   = 3'd2,
		CMD_APPEND = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_ZERO      = 3'd2;
	localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd3;
	localparam logic [STATUS_W-1:0] STS_BAD_NEXT  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'b1;

endpackage

// ----- rtl/core/fat_if.sv -----
// fat_if: valid/ready channel interfaces for commands, results and configuration.
// Depends on fat_pkg.
interface fat_req_if import fat_pkg::*;;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [BLK_W-1:0]   block;
	logic [CNT_W-1:0]   block_count;
	logic               has_tail;

	modport source (output valid, cmd, block, block_count, has_tail, input ready);
	modport sink   (input valid, cmd, block, block_count, has_tail, output ready);
endinterface

interface fat_rsp_if import fat_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BLK_W-1:0]    start_block;
	logic [ENTRY_W-1:0]  entry_value;

	modport source (output valid, status, start_block, entry_value, input ready);
	modport sink   (input valid, status, start_block, entry_value, output ready);
endinterface

interface fat_cfg_if import fat_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fat_ram.sv -----
// fat_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/fat_chain_allocator.sv -----
// fat_chain_allocator: allocation table with chain allocate, free, append, read, format.
// Depends on fat_pkg, fat_if (req/rsp/cfg channels) and fat_ram (table storage).
//
//  channel | dir | transaction carries
//  --------+-----+----------------------------------------------
//  req     | in  | cmd, block, block_count, has_tail
//  rsp     | out | status, start_block, entry_value (one per req)
//  cfg     | in  | index (0 volume block count, 1 reserved count), data
//
// One command at a time; the table lives in one RAM, one read and one write a cycle.
// Read: request, then capture. Free: each chain entry walked is read, then cleared.
// Allocate/append: entry check, scan to the spare, rescan to link, one entry a cycle.
// Format and the post-reset clear sweep all TABLE_DEPTH entries;
// no req is taken during the sweep, cfg writes are taken at all times.
// A finished result sits in the output register; the next req is taken meanwhile.
module fat_chain_allocator import fat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fat_req_if.sink    req,
	fat_rsp_if.source  rsp,
	fat_cfg_if.sink    cfg
);

	// one-hot sequencer states
	typedef enum logic [11:0] {
		ST_CLR  = 12'b0000_0000_0001, // sweep table (reset clear or format)
		ST_IDLE = 12'b0000_0000_0010,
		ST_AREQ = 12'b0000_0000_0100, // read entry at next-free
		ST_ACHK = 12'b0000_0000_1000, // check it is free
		ST_SCAN = 12'b0000_0001_0000, // count free blocks, find spare
		ST_LINK = 12'b0000_0010_0000, // rescan and write links
		ST_TAIL = 12'b0000_0100_0000, // link new block after tail
		ST_FRD  = 12'b0000_1000_0000, // read chain entry
		ST_FWR  = 12'b0001_0000_0000, // clear chain entry, follow link
		ST_RREQ = 12'b0010_0000_0000,
		ST_RDAT = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000  // hand result to output register
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [BLK_W-1:0]    blk_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                tail_q;
	logic [BLK_W-1:0]    nf_q;      // next-free pointer
	logic [CNT_W-1:0]    total_q;
	logic [BLK_W-1:0]    rsv_q;
	logic [CNT_W-1:0]    ca_q;      // sweep address
	logic                fmt_q;     // sweep is a format, not the reset clear
	logic [CNT_W-1:0]    ra_q;      // scan read address
	logic                v_s1;      // scan read in flight
	logic [BLK_W-1:0]    addr_s1;
	logic [CNT_W-1:0]    found_q;
	logic [CNT_W-1:0]    left_q;
	logic [BLK_W-1:0]    cur_q;
	logic [BLK_W-1:0]    spare_q;
	logic [CNT_W-1:0]    steps_q;
	logic                first_q;
	logic [STATUS_W-1:0] sts_q;
	logic [BLK_W-1:0]    start_q;
	logic [ENTRY_W-1:0]  value_q;
	logic                ov_q;
	logic [STATUS_W-1:0] o_sts_q;
	logic [BLK_W-1:0]    o_start_q;
	logic [ENTRY_W-1:0]  o_value_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic [CNT_W-1:0]    n;         // usable block count
	logic [CNT_W-1:0]    lim;       // entries marked end at format
	logic                issue;
	logic                scan_hit;
	logic [CNT_W-1:0]    steps_n;
	logic                free_stop;
	logic                out_free;
	logic [CNT_W-1:0]    req_cnt;

	fat_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign n   = (total_q > USABLE_MAX) ? USABLE_MAX : total_q;
	assign lim = ({1'b0, rsv_q} < n) ? {1'b0, rsv_q} : n;

	// scan/link reads stream upward one per cycle until the usable count
	assign issue    = ((state_q == ST_SCAN) || (state_q == ST_LINK)) && (ra_q < n);
	assign scan_hit = v_s1 && (ram_rdata == '0);

	// free walk stops at end mark, a null or out-of-range link, or the step bound
	assign steps_n   = steps_q + 1'b1;
	assign free_stop = (ram_rdata == END_MARK) || (ram_rdata == '0)
		|| (ram_rdata >= ENTRY_W'(n)) || (steps_n >= n);

	assign out_free  = !ov_q || rsp.ready;
	assign req_cnt   = (req.block_count == '0) ? CNT_W'(1) : req.block_count;

	assign req.ready       = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = ov_q;
	assign rsp.status      = o_sts_q;
	assign rsp.start_block = o_start_q;
	assign rsp.entry_value = o_value_q;

	// table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(cur_q);
		ram_wdata = '0;
		ram_raddr = ADDR_W'(ra_q);
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(ca_q);
				ram_wdata = (fmt_q && (ca_q < lim)) ? END_MARK : '0;
			end
			ST_AREQ: ram_raddr = ADDR_W'(cur_q);
			ST_LINK: begin
				if (left_q == '0) begin
					ram_we    = 1'b1;
					ram_wdata = END_MARK;
				end else if (scan_hit) begin
					ram_we    = 1'b1;
					ram_wdata = ENTRY_W'(addr_s1);
				end
			end
			ST_TAIL: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(blk_q);
				ram_wdata = ENTRY_W'(start_q);
			end
			ST_FRD: ram_raddr = ADDR_W'(cur_q);
			ST_FWR: ram_we = !(first_q && (ram_rdata == '0));
			ST_RREQ: ram_raddr = ADDR_W'(blk_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			cmd_q     <= CMD_FORMAT;
			blk_q     <= '0;
			cnt_q     <= '0;
			tail_q    <= 1'b0;
			nf_q      <= '0;
			total_q   <= TOTAL_RESET;
			rsv_q     <= RESERVED_RESET;
			ca_q      <= '0;
			fmt_q     <= 1'b0;
			ra_q      <= '0;
			v_s1      <= 1'b0;
			addr_s1   <= '0;
			found_q   <= '0;
			left_q    <= '0;
			cur_q     <= '0;
			spare_q   <= '0;
			steps_q   <= '0;
			first_q   <= 1'b0;
			sts_q     <= STS_OK;
			start_q   <= '0;
			value_q   <= '0;
			ov_q      <= 1'b0;
			o_sts_q   <= STS_OK;
			o_start_q <= '0;
			o_value_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_TOTAL:    total_q <= cfg.data;
					REG_RESERVED: rsv_q   <= BLK_W'(cfg.data);
					default: ;
				endcase
			end

			if (rsp.valid && rsp.ready) begin
				ov_q <= 1'b0;
			end

			v_s1    <= issue;
			addr_s1 <= BLK_W'(ra_q);
			if (issue) begin
				ra_q <= ra_q + 1'b1;
			end

			unique case (state_q)
				ST_CLR: begin
					ca_q <= ca_q + 1'b1;
					if (ca_q == LAST_ENTRY) begin
						if (fmt_q) begin
							nf_q    <= rsv_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q   <= cmd_t'(req.cmd);
						blk_q   <= req.block;
						tail_q  <= req.has_tail;
						sts_q   <= STS_OK;
						start_q <= '0;
						value_q <= '0;
						priority case (cmd_t'(req.cmd))
							CMD_FORMAT: begin
								fmt_q   <= 1'b1;
								ca_q    <= '0;
								state_q <= ST_CLR;
							end
							CMD_ALLOC, CMD_APPEND: begin
								cnt_q <= (cmd_t'(req.cmd) == CMD_APPEND) ? CNT_W'(1) : req_cnt;
								cur_q <= nf_q;
								if ({1'b0, nf_q} >= n) begin
									sts_q   <= STS_NO_SPACE;
									state_q <= ST_DONE;
								end else if (nf_q == '0) begin
									sts_q   <= STS_ZERO;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_AREQ;
								end
							end
							CMD_FREE: begin
								cur_q   <= req.block;
								first_q <= 1'b1;
								steps_q <= '0;
								if (req.block == '0) begin
									sts_q   <= STS_ZERO;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_FRD;
								end
							end
							CMD_READ: state_q <= ST_RREQ;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_AREQ: state_q <= ST_ACHK;
				ST_ACHK: begin
					if (ram_rdata != '0) begin
						sts_q   <= STS_BAD_NEXT;
						state_q <= ST_DONE;
					end else begin
						ra_q    <= {1'b0, nf_q} + 1'b1;
						found_q <= CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						if (found_q < cnt_q) begin
							found_q <= found_q + 1'b1;
						end else begin
							// enough blocks plus a spare: go back and link them
							spare_q <= addr_s1;
							ra_q    <= {1'b0, nf_q} + 1'b1;
							left_q  <= cnt_q - 1'b1;
							v_s1    <= 1'b0;
							state_q <= ST_LINK;
						end
					end else if (!v_s1 && !issue) begin
						sts_q   <= STS_NO_SPACE;
						state_q <= ST_DONE;
					end
				end
				ST_LINK: begin
					if (left_q == '0) begin
						nf_q    <= spare_q;
						start_q <= nf_q;
						if ((cmd_q == CMD_APPEND) && tail_q && ({1'b0, blk_q} < n)
							&& (blk_q != nf_q)) begin
							state_q <= ST_TAIL;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (scan_hit) begin
						cur_q  <= addr_s1;
						left_q <= left_q - 1'b1;
					end
				end
				ST_TAIL: state_q <= ST_DONE;
				ST_FRD:  state_q <= ST_FWR;
				ST_FWR: begin
					if (first_q && (ram_rdata == '0)) begin
						sts_q   <= STS_NOT_ALLOC;
						state_q <= ST_DONE;
					end else begin
						steps_q <= steps_n;
						first_q <= 1'b0;
						if (free_stop) begin
							if (blk_q < nf_q) begin
								nf_q <= blk_q;
							end
							state_q <= ST_DONE;
						end else begin
							cur_q   <= BLK_W'(ram_rdata);
							state_q <= ST_FRD;
						end
					end
				end
				ST_RREQ: state_q <= ST_RDAT;
				ST_RDAT: begin
					value_q <= ram_rdata;
					sts_q   <= (ram_rdata == '0) ? STS_NOT_ALLOC : STS_OK;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						ov_q      <= 1'b1;
						o_sts_q   <= sts_q;
						o_start_q <= start_q;
						o_value_q <= value_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the counting scan and the entry check never modify the table
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) || (state_q == ST_ACHK)) |-> !ram_we)
		else $error("table written during allocation scan");

	// a completed link pass leaves a non-zero next-free pointer
	a_nf_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LINK) && (left_q == '0)) |=> (nf_q != '0))
		else $error("next-free zero after allocation");

	// the count of blocks seen never overruns the request
	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((found_q <= cnt_q) && (found_q != '0)))
		else $error("scan count out of range");

	// link writes always land below the read stream
	a_link_order: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LINK) && ram_we && v_s1) |-> (cur_q < addr_s1))
		else $error("link write overtakes scan read");

endmodule
